>>> design/fcsw_pkg.sv
`default_nettype none
package fcsw_pkg;

    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRAILER_LENGTH = 2'd1;

    localparam logic [15:0] FRAME_LENGTH_RST   = 16'd33033;
    localparam logic [11:0] TRAILER_LENGTH_RST = 12'd233;

    // one entry of the queue: up to four output words pushed for one input word
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            frame_end;
    } t_job;

endpackage
`default_nettype wire

>>> design/fcsw_front.sv
`default_nettype none
module fcsw_front import fcsw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    input  wire logic [7:0]            i_in_byte,
    input  wire logic                  i_q_full,
    output logic                       o_stall,
    output logic                       o_push,
    output t_job                       o_job
);

    logic [15:0]        r_frame_len;
    logic [11:0]        r_trl_len;
    logic [15:0]        r_pos;
    logic [31:0]        r_sum;
    logic [2:0][7:0]    r_held;

    logic [16:0]        len_full;
    logic signed [17:0] csum_at;
    logic signed [17:0] pos_s;
    logic               at_end;
    logic               hold;
    logic               accept;
    logic               multi;
    logic               csum_hit;
    logic [1:0]         csum_k;
    logic [7:0]         v;
    logic [31:0]        add_word;
    t_job               job;

    function automatic logic in_region(input logic [15:0] p, input logic signed [17:0] c);
        logic signed [17:0] ps;
        ps = $signed({2'b00, p});
        return (p >= 16'd4) && (ps < c);
    endfunction

    always_comb begin
        len_full = (r_frame_len == 16'd0) ? 17'h10000 : {1'b0, r_frame_len};
        csum_at  = $signed({1'b0, len_full}) - $signed({6'd0, r_trl_len}) - 18'sd4;
        pos_s    = $signed({2'b00, r_pos});
        at_end   = {1'b0, r_pos} >= (len_full - 17'd1);
        hold     = (r_pos >= 16'd12) && (r_pos <= 16'd14) && !at_end;
        accept   = i_valid && !i_q_full;
        multi    = (r_pos >= 16'd13) && (r_pos <= 16'd15);

        // checksum field: four bytes right before the trailer
        csum_hit = (csum_at >= 18'sd16) && (pos_s >= csum_at) && (pos_s < csum_at + 18'sd4);
        csum_k   = r_pos[1:0] - csum_at[1:0];
        v        = i_in_byte;
        if (csum_hit) begin
            if (csum_at[1:0] == 2'd0) begin
                v = r_sum[{~csum_k, 3'b000} +: 8];
            end else begin
                v = 8'd0;
            end
        end

        job.bytes     = '0;
        job.last_idx  = 2'd0;
        job.frame_end = at_end;
        if (r_pos == 16'd15) begin
            // count fields swapped
            job.bytes[0] = r_held[2];
            job.bytes[1] = i_in_byte;
            job.bytes[2] = r_held[0];
            job.bytes[3] = r_held[1];
            job.last_idx = 2'd3;
        end else if (r_pos == 16'd13) begin
            job.bytes[0] = r_held[0];
            job.bytes[1] = i_in_byte;
            job.last_idx = 2'd1;
        end else if (r_pos == 16'd14) begin
            job.bytes[0] = r_held[0];
            job.bytes[1] = r_held[1];
            job.bytes[2] = i_in_byte;
            job.last_idx = 2'd2;
        end else begin
            job.bytes[0] = v;
        end

        add_word = '0;
        if (multi) begin
            // bytes from offset 12 fill one aligned word
            for (int j = 0; j < 4; j++) begin
                if ((2'(j) <= job.last_idx) && in_region(16'(12 + j), csum_at)) begin
                    add_word[8*(3-j) +: 8] = job.bytes[j];
                end
            end
        end else if (in_region(r_pos, csum_at)) begin
            add_word = {24'd0, v} << {~r_pos[1:0], 3'b000};
        end
    end

    assign o_stall = i_q_full;
    assign o_push  = accept && !hold;
    assign o_job   = job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LENGTH_RST;
            r_trl_len   <= TRAILER_LENGTH_RST;
            r_pos       <= '0;
            r_sum       <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_FRAME_LENGTH:   r_frame_len <= i_cfg_data;
                    REG_TRAILER_LENGTH: r_trl_len   <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (hold) begin
                    r_pos <= r_pos + 16'd1;
                end else if (at_end) begin
                    r_pos <= '0;
                    r_sum <= '0;
                end else begin
                    r_pos <= r_pos + 16'd1;
                    r_sum <= r_sum + add_word;
                end
            end
        end
    end

    // bytes 12 to 14 wait here for the swap
    always_ff @(posedge i_clk) begin
        if (accept && hold) begin
            r_held[r_pos[1:0]] <= i_in_byte;
        end
    end

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && at_end |=> (r_pos == 16'd0) && (r_sum == 32'd0))
        else $error("position or sum not cleared at frame end");
    a_swap_four: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && (r_pos == 16'd15) |-> (o_job.last_idx == 2'd3))
        else $error("swap did not produce four words");
    a_hold_no_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && hold |=> (r_pos == $past(r_pos) + 16'd1) && (r_sum == $past(r_sum)))
        else $error("held word changed the sum");

endmodule
`default_nettype wire

>>> design/fcsw_queue.sv
`default_nettype none
module fcsw_queue import fcsw_pkg::*; #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_job      i_job,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_valid,
    output t_job      o_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

endmodule
`default_nettype wire

>>> design/fcsw_back.sv
`default_nettype none
module fcsw_back import fcsw_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_valid,
    input  t_job      i_job,
    output logic      o_pop,
    input  wire logic i_stall,
    output logic      o_valid,
    output logic [7:0] o_out_byte,
    output logic      o_frame_end,
    output logic      o_last
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_frame_end;
    logic       r_last;
    logic [1:0] r_idx;

    logic load;
    logic is_last;

    assign load    = !r_valid || !i_stall;
    assign is_last = (r_idx == i_job.last_idx);
    assign o_pop   = load && i_q_valid && is_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= is_last ? 2'd0 : r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_byte      <= i_job.bytes[r_idx];
            r_last      <= is_last;
            r_frame_end <= is_last && i_job.frame_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_frame_end;
    assign o_last      = r_last;

    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!o_frame_end || o_last))
        else $error("frame end on a word that is not last");
    a_mid_job_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != 2'd0) |-> i_q_valid)
        else $error("queue head lost in the middle of a burst");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_valid |-> (r_idx <= i_job.last_idx))
        else $error("burst index past last word");

endmodule
`default_nettype wire

>>> design/frame_count_swap_and_word_sum_fixup.sv
// channel   direction  handshake            payload
// input     in         i_valid / o_stall    i_in_byte
// output    out        o_valid / i_stall    o_out_byte, o_frame_end, o_last
// config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// one input word per cycle unless stalled; each gives one output word, except
// byte 15 (and a frame ending at 13 or 14), whose up to four words leave one per
// cycle. bytes 12 to 14 give no output until byte 15; at full rate the burst
// fills the default four-entry queue and stalls the input each frame. a word
// passes the queue, then the output register. o_stall rises only when the queue
// is full; i_stall holds the output. sync reset clears pos, sum, queue.
`default_nettype none
module frame_count_swap_and_word_sum_fixup import fcsw_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire logic [7:0]            i_in_byte,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [7:0]                 o_out_byte,
    output logic                       o_frame_end,
    output logic                       o_last
);

    logic q_full;
    logic q_valid;
    logic push;
    logic pop;
    t_job push_job;
    t_job head_job;

    fcsw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_stall    (o_stall),
        .o_push     (push),
        .o_job      (push_job)
    );

    fcsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    fcsw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (pop),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_out_byte  (o_out_byte),
        .o_frame_end (o_frame_end),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
